/* hw/rtl/ccdp_pkg.sv */
// ----------------------------------------------------------------------------
// ccdp_pkg - shared types and constants of the Cache-Control directive parser
// Holds the parser state record, the keyword table, character codes and the
// reset value of the parse state.
// ----------------------------------------------------------------------------
package ccdp_pkg;

   localparam int KW_COUNT = 8;

   // Saturation point of a delta-seconds argument and the largest reachable value
   localparam logic [29:0] CAP_VALUE = 30'd100000000;
   localparam logic [29:0] AGE_LIMIT = 30'd1000000009;

   // Character codes
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

   // Keyword bit positions in the candidate and hit vectors
   localparam int KW_MAX_AGE  = 6;
   localparam int KW_SMAX_AGE = 7;

   // Keyword text, right-justified: first character at the high end
   localparam logic [127:0] KW_TEXT [KW_COUNT] = '{
      128'("no-store"), 128'("no-cache"), 128'("must-revalidate"), 128'("private"),
      128'("public"), 128'("immutable"), 128'("max-age"), 128'("s-maxage")
   };
   localparam logic [4:0] KW_LEN [KW_COUNT] = '{
      5'd8, 5'd8, 5'd15, 5'd7, 5'd6, 5'd9, 5'd7, 5'd8
   };

   // Argument parse mode
   typedef enum logic [1:0] {
      MODE_EMPTY,
      MODE_DIGITS,
      MODE_SAT,
      MODE_BAD
   } arg_mode_type;

   // Complete parser state carried between transfers
   typedef struct packed {
      logic         quote_open;
      logic         in_arg;
      logic [7:0]   candidates;
      logic [4:0]   name_len;
      logic         pending_space;
      logic [29:0]  arg_value;
      arg_mode_type arg_mode;
      logic         arg_opened;
      logic         arg_qpend;
      logic [5:0]   seen;
      logic         max_age_present;
      logic [29:0]  max_age;
      logic         smax_age_present;
      logic [29:0]  smax_age;
   } parse_state_type;

   // One result transfer
   typedef struct packed {
      logic        nostore_seen;
      logic        nocache_seen;
      logic        revalidate_seen;
      logic        private_seen;
      logic        public_seen;
      logic        immutable;
      logic        max_age_present;
      logic [29:0] max_age;
      logic        shared_max_age_present;
      logic [29:0] shared_max_age;
   } result_type;

   // Character of keyword k at position idx (idx below the keyword length)
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] idx);
      logic [127:0] text;
      logic [3:0]   pos;
      text = KW_TEXT[k];
      pos  = KW_LEN[k][3:0] - 4'd1 - idx;
      return text[{pos, 3'b000} +: 8];
   endfunction

   // State at reset and at the start of every header
   function automatic parse_state_type parse_state_reset();
      parse_state_type s;
      s            = '0;
      s.candidates = '1;
      s.arg_mode   = MODE_EMPTY;
      return s;
   endfunction

endpackage

/* hw/rtl/ccdp_lex.sv */
// ----------------------------------------------------------------------------
// ccdp_lex - one-character step of the Cache-Control directive parser
// Combinational: applies one header byte to the parse state, closes the open
// directive on an unquoted comma or on the final byte and builds the result record.
// ----------------------------------------------------------------------------
module ccdp_lex (
   input  ccdp_pkg::parse_state_type state_cur,
   input  logic                      has_byte,
   input  logic [7:0]                byte_req,
   input  logic                      last,
   output ccdp_pkg::parse_state_type state_next,
   output ccdp_pkg::result_type      result
);
   import ccdp_pkg::*;

   // Argument of the closing directive, bit 30 is the present flag
   function automatic logic [30:0] finish_arg(input parse_state_type s);
      logic good;
      good = (s.arg_mode == MODE_DIGITS) || (s.arg_mode == MODE_SAT);
      if (s.arg_opened && !s.arg_qpend) begin
         good = 1'b0;
      end
      if (!s.in_arg || !good) begin
         return '0;
      end
      return {1'b1, s.arg_value};
   endfunction

   // Close the open directive: record hits and start a fresh name
   function automatic parse_state_type end_directive(input parse_state_type s_in);
      parse_state_type s;
      logic [7:0]      hits;
      logic [30:0]     arg;
      s   = s_in;
      arg = finish_arg(s_in);
      for (int i = 0; i < KW_COUNT; i++) begin
         hits[i] = s_in.candidates[i] && (s_in.name_len == KW_LEN[i]);
      end
      s.seen = s.seen | hits[5:0];
      if (hits[KW_MAX_AGE]) begin
         s.max_age_present = arg[30];
         s.max_age         = arg[29:0];
      end
      if (hits[KW_SMAX_AGE]) begin
         s.smax_age_present = arg[30];
         s.smax_age         = arg[29:0];
      end
      s.in_arg        = 1'b0;
      s.candidates    = '1;
      s.name_len      = '0;
      s.pending_space = 1'b0;
      s.arg_value     = '0;
      s.arg_mode      = MODE_EMPTY;
      s.arg_opened    = 1'b0;
      s.arg_qpend     = 1'b0;
      return s;
   endfunction

   function automatic arg_mode_type bad_mode(input arg_mode_type m);
      return (m == MODE_SAT) ? MODE_SAT : MODE_BAD;
   endfunction

   logic            is_space;
   logic            is_digit;
   logic [7:0]      lower_c;
   parse_state_type s;
   parse_state_type s_end;

   // Character classes
   always_comb begin
      is_space = (byte_req == CHAR_SPACE) || ((byte_req >= CHAR_TAB) && (byte_req <= CHAR_CR));
      is_digit = (byte_req >= CHAR_ZERO) && (byte_req <= CHAR_NINE);
      lower_c  = ((byte_req >= CHAR_UPPER_A) && (byte_req <= CHAR_UPPER_Z)) ?
                 (byte_req | 8'h20) : byte_req;
   end

   // Apply the byte
   always_comb begin
      s = state_cur;
      if (has_byte) begin
         if (byte_req == CHAR_QUOTE) begin
            s.quote_open = ~s.quote_open;
         end
         if ((byte_req == CHAR_COMMA) && !s.quote_open) begin
            s = end_directive(state_cur);
         end else if (!s.in_arg) begin
            // directive name
            if (byte_req == CHAR_EQUAL) begin
               s.in_arg        = 1'b1;
               s.pending_space = 1'b0;
            end else if (is_space) begin
               if (s.name_len != '0) begin
                  s.pending_space = 1'b1;
               end
            end else begin
               if (s.pending_space) begin
                  s.candidates    = '0;
                  s.pending_space = 1'b0;
               end
               for (int i = 0; i < KW_COUNT; i++) begin
                  if (!((s.name_len < KW_LEN[i]) &&
                        (kw_char(3'(i), s.name_len[3:0]) == lower_c))) begin
                     s.candidates[i] = 1'b0;
                  end
               end
               if (s.name_len != 5'd31) begin
                  s.name_len = s.name_len + 5'd1;
               end
            end
         end else begin
            // directive argument
            if (is_space) begin
               if ((s.arg_mode != MODE_EMPTY) || s.arg_opened) begin
                  s.pending_space = 1'b1;
               end
            end else if ((s.arg_mode == MODE_EMPTY) && !s.arg_opened && !s.pending_space &&
                         (byte_req == CHAR_QUOTE)) begin
               s.arg_opened = 1'b1;
            end else begin
               if (s.arg_qpend) begin
                  s.arg_mode  = bad_mode(s.arg_mode);
                  s.arg_qpend = 1'b0;
               end
               if (s.pending_space) begin
                  s.arg_mode      = bad_mode(s.arg_mode);
                  s.pending_space = 1'b0;
               end
               if (s.arg_opened && (byte_req == CHAR_QUOTE)) begin
                  s.arg_qpend = 1'b1;
               end else if (!is_digit) begin
                  s.arg_mode = bad_mode(s.arg_mode);
               end else if ((s.arg_mode == MODE_DIGITS) && (s.arg_value > CAP_VALUE)) begin
                  s.arg_value = CAP_VALUE;
                  s.arg_mode  = MODE_SAT;
               end else if ((s.arg_mode == MODE_EMPTY) || (s.arg_mode == MODE_DIGITS)) begin
                  // value * 10 + digit; stays below 2^30 as the value is capped first
                  s.arg_value = ((s.arg_mode == MODE_EMPTY) ? 30'd0 :
                                 ((s.arg_value << 3) + (s.arg_value << 1))) +
                                {26'd0, byte_req[3:0]};
                  s.arg_mode  = MODE_DIGITS;
               end
            end
         end
      end
   end

   // Header end: close the directive, report, restart
   always_comb begin
      s_end                         = end_directive(s);
      result.nostore_seen           = s_end.seen[0];
      result.nocache_seen           = s_end.seen[1];
      result.revalidate_seen        = s_end.seen[2];
      result.private_seen           = s_end.seen[3];
      result.public_seen            = s_end.seen[4];
      result.immutable              = s_end.seen[5];
      result.max_age_present        = s_end.max_age_present;
      result.max_age                = s_end.max_age;
      result.shared_max_age_present = s_end.smax_age_present;
      result.shared_max_age         = s_end.smax_age;
      state_next                    = last ? parse_state_reset() : s;
   end

endmodule

/* hw/rtl/cache_control_directive_parser.sv */
// ----------------------------------------------------------------------------
// cache_control_directive_parser - Cache-Control header value parser
// Takes a header value one byte per transfer and reports the cache
// directives found once the final byte has arrived.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one transfer per header byte; req_last marks the
//   final byte. A transfer with req_has_byte low carries no character and
//   serves to close an empty header (with req_last high).
//   Response channel (rsp_*): one transfer per header, carrying the six
//   directive flags and the max-age / s-maxage arguments.
//   Throughput: one request transfer per cycle while req_stall is low. Each
//   byte passes an input register and a single combinational parse step;
//   the final byte's result goes to the result register, and rsp_valid
//   rises with it, unless an earlier result is still held there.
//   Stall: when the response register holds an untaken result and the
//   receiver stalls, the final byte of the next header waits in the input
//   register and req_stall rises; a byte that is not final never waits there.
//   Reset clears the valid flags of both registers and the parse state;
//   nothing needs configuring.
// ----------------------------------------------------------------------------
module cache_control_directive_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_has_byte,
   input  logic [7:0]  req_byte_req,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_nostore_seen,
   output logic        rsp_nocache_seen,
   output logic        rsp_revalidate_seen,
   output logic        rsp_private_seen,
   output logic        rsp_public_seen,
   output logic        rsp_immutable,
   output logic        rsp_max_age_present,
   output logic [29:0] rsp_max_age,
   output logic        rsp_shared_max_age_present,
   output logic [29:0] rsp_shared_max_age
);
   import ccdp_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic            in_has_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            req_accept;
   logic            step_fire;
   parse_state_type state_ff, state_in;
   parse_state_type step_state;
   result_type      step_result;
   logic            out_valid_ff, out_valid_in;
   result_type      out_ff;

   // Handshake: only a final byte needs room in the result register
   assign step_fire  = in_valid_ff && (!in_last_ff || !out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !step_fire;
   assign req_accept = req_valid && !req_stall;

   // Input register
   assign in_valid_in = req_accept ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_has_ff  <= req_has_byte;
         in_byte_ff <= req_byte_req;
         in_last_ff <= req_last;
      end
   end

   // Parse step
   ccdp_lex u_lex (
      .state_cur  (state_ff),
      .has_byte   (in_has_ff),
      .byte_req   (in_byte_ff),
      .last       (in_last_ff),
      .state_next (step_state),
      .result     (step_result)
   );

   assign state_in = step_fire ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= parse_state_reset();
      end else begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (step_fire && in_last_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step_fire && in_last_ff) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid                  = out_valid_ff;
   assign rsp_nostore_seen           = out_ff.nostore_seen;
   assign rsp_nocache_seen           = out_ff.nocache_seen;
   assign rsp_revalidate_seen        = out_ff.revalidate_seen;
   assign rsp_private_seen           = out_ff.private_seen;
   assign rsp_public_seen            = out_ff.public_seen;
   assign rsp_immutable              = out_ff.immutable;
   assign rsp_max_age_present        = out_ff.max_age_present;
   assign rsp_max_age                = out_ff.max_age;
   assign rsp_shared_max_age_present = out_ff.shared_max_age_present;
   assign rsp_shared_max_age         = out_ff.shared_max_age;

   // Checks
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_last_ff |=> out_valid_ff)
      else $error("final byte processed without a result");

   a_state_restarts: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_last_ff |=> state_ff == parse_state_reset())
      else $error("parse state not restarted after header end");

   a_mid_bytes_flow: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_last_ff |-> !req_stall)
      else $error("stall raised for a byte that needs no result slot");

   a_age_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.max_age <= AGE_LIMIT && state_ff.smax_age <= AGE_LIMIT &&
      state_ff.arg_value <= AGE_LIMIT)
      else $error("argument value beyond its saturation limit");

   a_absent_is_zero: assert property (@(posedge clock) disable iff (reset)
      (!state_ff.max_age_present |-> state_ff.max_age == '0) and
      (!state_ff.smax_age_present |-> state_ff.smax_age == '0))
      else $error("absent argument carries a nonzero value");

endmodule
